### rtl/pid_stp_pkg.sv
// Package for the PID controller step unit: Q16.16 types, register indexes
// and the saturating arithmetic helpers shared by the RTL files.
// No dependencies.
package pid_stp_pkg;

  typedef logic signed [31:0] q16_t;
  typedef logic signed [63:0] qprod_t;

  localparam q16_t Q16_MAX    = 32'sh7FFF_FFFF;
  localparam q16_t Q16_MIN    = 32'sh8000_0000;
  // Speed-mode deadband of 10.0 in Q16.16.
  localparam q16_t DEADBAND_Q = 32'sd655360;
  localparam q16_t Q16_ZERO   = 32'sd0;

  typedef enum logic [2:0] {
    REG_KP_GAIN      = 3'd0,
    REG_KI_DT_GAIN   = 3'd1,
    REG_KD_DT_GAIN   = 3'd2,
    REG_INCR_MODE    = 3'd3,
    REG_DRIVE_LOW    = 3'd4,
    REG_DRIVE_HIGH   = 3'd5,
    REG_ACCUM_LOW    = 3'd6,
    REG_ACCUM_HIGH   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic hit;
    q16_t val;
  } clamp_res_t;

  // Saturate a 34-bit signed sum to 32 bits.
  function automatic q16_t sat34(input logic signed [33:0] x);
    q16_t r;
    if (x[33:31] == 3'b000 || x[33:31] == 3'b111) begin
      r = x[31:0];
    end else if (x[33]) begin
      r = Q16_MIN;
    end else begin
      r = Q16_MAX;
    end
    return r;
  endfunction

  function automatic q16_t sat_add(input q16_t a, input q16_t b);
    logic signed [33:0] s;
    s = 34'(a) + 34'(b);
    return sat34(s);
  endfunction

  function automatic q16_t sat_sub(input q16_t a, input q16_t b);
    logic signed [33:0] s;
    s = 34'(a) - 34'(b);
    return sat34(s);
  endfunction

  function automatic q16_t sat_add3(input q16_t a, input q16_t b, input q16_t c);
    logic signed [33:0] s;
    s = 34'(a) + 34'(b) + 34'(c);
    return sat34(s);
  endfunction

  // Product of two Q16.16 values, floored by 2^16 and saturated. The floored
  // quotient is bits 63:16; it fits 32 bits when bits 63:47 agree.
  function automatic q16_t qsat(input qprod_t p);
    q16_t r;
    if (p[63:47] == 17'h00000 || p[63:47] == 17'h1FFFF) begin
      r = p[47:16];
    end else if (p[63]) begin
      r = Q16_MIN;
    end else begin
      r = Q16_MAX;
    end
    return r;
  endfunction

  // Limit clamp; disabled when both limits are equal. The high limit is
  // tested first so that crossed limits behave predictably.
  function automatic clamp_res_t clamp_lim(input q16_t v, input q16_t lo, input q16_t hi);
    clamp_res_t r;
    r.hit = 1'b0;
    r.val = v;
    if (lo != hi) begin
      if (v > hi) begin
        r.hit = 1'b1;
        r.val = hi;
      end else if (v < lo) begin
        r.hit = 1'b1;
        r.val = lo;
      end
    end
    return r;
  endfunction

endpackage

### rtl/pid_stp_if.sv
// Valid/ready channel interfaces for the PID controller step unit.
// Depends on pid_stp_pkg for the Q16.16 type.
interface pid_stp_in_if;
  import pid_stp_pkg::*;

  logic valid;
  logic ready;
  q16_t setpoint;
  q16_t measurement;

  modport source (output valid, output setpoint, output measurement, input ready);
  modport sink   (input valid, input setpoint, input measurement, output ready);
endinterface

interface pid_stp_out_if;
  import pid_stp_pkg::*;

  logic valid;
  logic ready;
  q16_t drive;
  logic drive_clamped;

  modport source (output valid, output drive, output drive_clamped, input ready);
  modport sink   (input valid, input drive, input drive_clamped, output ready);
endinterface

### rtl/pid_stp_qmul.sv
// Registered 32x32 signed multiplier used for the three PID gain products.
// Depends on pid_stp_pkg for the operand and product types.
module pid_stp_qmul (
  input  logic                clk,
  input  logic                en,
  input  pid_stp_pkg::q16_t   a,
  input  pid_stp_pkg::q16_t   b,
  output pid_stp_pkg::qprod_t prod_r
);
  import pid_stp_pkg::*;

  qprod_t prod_nxt;

  assign prod_nxt = qprod_t'(a) * qprod_t'(b);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

### rtl/pid_controller_step_unit.sv
// Top level of the PID controller step unit: six-stage pipeline with
// configuration registers. Depends on pid_stp_pkg, the channel interfaces
// and pid_stp_qmul.

// One setpoint/measurement beat produces one drive beat, which is offered on
// the result channel once it has passed through every stage. A new beat
// is taken every cycle while the result side keeps up. The
// stages are: input register, error and error difference, the three gain
// products, integral update, P+I+D sum, and speed-mode accumulation with the
// drive clamp and deadband. The integral and previous drive feed back within
// their own stage, so consecutive beats see the state exactly as a one-at-a-
// time controller would. Configuration may only be written while the
// pipeline is empty.
module pid_controller_step_unit (
  input  logic                   clk,
  input  logic                   rst_n,
  pid_stp_in_if.sink             in_chan,
  pid_stp_out_if.source          out_chan,
  input  logic                   cfg_we,
  input  pid_stp_pkg::cfg_reg_t  cfg_index,
  input  pid_stp_pkg::q16_t      cfg_wdata
);
  import pid_stp_pkg::*;

  // Configuration registers.
  q16_t kp_r, ki_dt_r, kd_dt_r;
  logic incr_r;
  q16_t drv_lo_r, drv_hi_r, acc_lo_r, acc_hi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r     <= Q16_ZERO;
      ki_dt_r  <= Q16_ZERO;
      kd_dt_r  <= Q16_ZERO;
      incr_r   <= 1'b0;
      drv_lo_r <= Q16_ZERO;
      drv_hi_r <= Q16_ZERO;
      acc_lo_r <= Q16_ZERO;
      acc_hi_r <= Q16_ZERO;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KP_GAIN:    kp_r     <= cfg_wdata;
        REG_KI_DT_GAIN: ki_dt_r  <= cfg_wdata;
        REG_KD_DT_GAIN: kd_dt_r  <= cfg_wdata;
        REG_INCR_MODE:  incr_r   <= cfg_wdata[0];
        REG_DRIVE_LOW:  drv_lo_r <= cfg_wdata;
        REG_DRIVE_HIGH: drv_hi_r <= cfg_wdata;
        REG_ACCUM_LOW:  acc_lo_r <= cfg_wdata;
        REG_ACCUM_HIGH: acc_hi_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Stage valids and the ready chain; a stage loads when it is empty or its
  // successor is loading, which lets bubbles collapse.
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
  logic ld1, ld2, ld3, ld4, ld5, ld6;

  assign rdy6 = !v6_r || out_chan.ready;
  assign rdy5 = !v5_r || rdy6;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign ld1 = rdy1 && in_chan.valid;
  assign ld2 = rdy2 && v1_r;
  assign ld3 = rdy3 && v2_r;
  assign ld4 = rdy4 && v3_r;
  assign ld5 = rdy5 && v4_r;
  assign ld6 = rdy6 && v5_r;

  assign in_chan.ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_chan.valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
      if (rdy6) v6_r <= v5_r;
    end
  end

  // Stage 1: input register.
  q16_t sp1_r, meas1_r;

  always_ff @(posedge clk) begin
    if (ld1) begin
      sp1_r   <= in_chan.setpoint;
      meas1_r <= in_chan.measurement;
    end
  end

  // Stage 2: error and difference against the previous error.
  q16_t err_nxt, diff_nxt;
  q16_t err2_r, diff2_r, prev_err_r;
  logic spz2_r;

  assign err_nxt  = sat_sub(sp1_r, meas1_r);
  assign diff_nxt = sat_sub(err_nxt, prev_err_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_err_r <= Q16_ZERO;
    end else if (ld2) begin
      prev_err_r <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld2) begin
      err2_r  <= err_nxt;
      diff2_r <= diff_nxt;
      spz2_r  <= (sp1_r == Q16_ZERO);
    end
  end

  // Stage 3: gain products.
  qprod_t pp3_r, pi3_r, pd3_r;
  logic   spz3_r;

  pid_stp_qmul u_mul_p (.clk(clk), .en(ld3), .a(kp_r),    .b(err2_r),  .prod_r(pp3_r));
  pid_stp_qmul u_mul_i (.clk(clk), .en(ld3), .a(err2_r),  .b(ki_dt_r), .prod_r(pi3_r));
  pid_stp_qmul u_mul_d (.clk(clk), .en(ld3), .a(kd_dt_r), .b(diff2_r), .prod_r(pd3_r));

  always_ff @(posedge clk) begin
    if (ld3) begin
      spz3_r <= spz2_r;
    end
  end

  // Stage 4: integral update. The drive uses the clamped integral; a zero
  // setpoint clears only what the next beat sees.
  q16_t       acc_r;
  clamp_res_t acc_cl;
  q16_t       pp4_r, pd4_r, acc4_r;

  assign acc_cl = clamp_lim(sat_add(acc_r, qsat(pi3_r)), acc_lo_r, acc_hi_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= Q16_ZERO;
    end else if (ld4) begin
      acc_r <= spz3_r ? Q16_ZERO : acc_cl.val;
    end
  end

  always_ff @(posedge clk) begin
    if (ld4) begin
      pp4_r  <= qsat(pp3_r);
      pd4_r  <= qsat(pd3_r);
      acc4_r <= acc_cl.val;
    end
  end

  // Stage 5: P+I+D, summed exactly and saturated once.
  q16_t sum5_r;

  always_ff @(posedge clk) begin
    if (ld5) begin
      sum5_r <= sat_add3(pp4_r, acc4_r, pd4_r);
    end
  end

  // Stage 6: speed-mode accumulation, drive clamp and deadband.
  q16_t       prev_drv_r;
  q16_t       acc_drv;
  clamp_res_t drv_cl;
  q16_t       drive_nxt;
  q16_t       drive6_r;
  logic       clamped6_r;

  always_comb begin
    acc_drv   = incr_r ? sat_add(sum5_r, prev_drv_r) : sum5_r;
    drv_cl    = clamp_lim(acc_drv, drv_lo_r, drv_hi_r);
    drive_nxt = drv_cl.val;
    if (incr_r && drv_cl.val > -DEADBAND_Q && drv_cl.val < DEADBAND_Q) begin
      drive_nxt = Q16_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_drv_r <= Q16_ZERO;
    end else if (ld6) begin
      prev_drv_r <= drive_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld6) begin
      drive6_r   <= drive_nxt;
      clamped6_r <= drv_cl.hit;
    end
  end

  assign out_chan.valid         = v6_r;
  assign out_chan.drive         = drive6_r;
  assign out_chan.drive_clamped = clamped6_r;

endmodule

### rtl/pid_stp_checker.sv
// Port-level checker for the PID controller step unit, bound to the top
// level. Depends on pid_stp_pkg and on the top level's channel ports.
module pid_stp_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input pid_stp_pkg::q16_t out_drive,
  input logic              out_drive_clamped
);
  import pid_stp_pkg::*;

  // Beats accepted at the input and not yet delivered; the pipeline holds
  // at most six.
  logic [2:0] inflight_r;
  logic [2:0] inflight_nxt;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    inflight_nxt = inflight_r;
    if (in_acc && !out_acc) begin
      inflight_nxt = inflight_r + 3'd1;
    end else if (out_acc && !in_acc) begin
      inflight_nxt = inflight_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= 3'd0;
    end else begin
      inflight_r <= inflight_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat withdrawn before it was taken");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_drive) && $stable(out_drive_clamped))
    else $error("stalled result beat changed");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> inflight_r != 3'd0)
    else $error("result beat without a matching input beat");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= 3'd6)
    else $error("more beats in flight than pipeline stages");

endmodule

bind pid_controller_step_unit pid_stp_checker u_pid_stp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_chan.valid),
  .in_ready          (in_chan.ready),
  .out_valid         (out_chan.valid),
  .out_ready         (out_chan.ready),
  .out_drive         (out_chan.drive),
  .out_drive_clamped (out_chan.drive_clamped)
);

### tb/sv/pid_step_checker.sv
// Scoreboard for the PID controller step unit: tracks register writes, predicts
// the drive of every accepted setpoint/measurement beat and compares results.
// Depends on pid_stp_pkg and the channel interfaces in pid_stp_if.sv.
module pid_step_checker (
  input  logic                  clk,
  input  logic                  rst_n,
  pid_stp_in_if                 in_mon,
  pid_stp_out_if                out_mon,
  input  logic                  cfg_we,
  input  pid_stp_pkg::cfg_reg_t cfg_index,
  input  pid_stp_pkg::q16_t     cfg_wdata,
  output int                    error_count,
  output int                    outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import pid_stp_pkg::*;

  typedef struct packed {
    q16_t drive;
    logic clamped;
  } drive_beat_t;

  // Register copies
  q16_t kp, ki_dt, kd_dt;
  logic speed_mode;
  q16_t drv_lo, drv_hi, acc_lo, acc_hi;

  // Controller state
  q16_t integral, prior_error, last_drive;

  drive_beat_t predicted_drives[$];

  function automatic q16_t clip_q16(input longint x);
    if (x > longint'(Q16_MAX)) return Q16_MAX;
    if (x < longint'(Q16_MIN)) return Q16_MIN;
    return q16_t'(x);
  endfunction

  // The arithmetic shift floors the exact product towards minus infinity.
  function automatic q16_t mul_q16(input q16_t a, input q16_t b);
    longint p;
    p = longint'(a) * longint'(b);
    return clip_q16(p >>> 16);
  endfunction

  function automatic q16_t bound_q16(input q16_t v, input q16_t lo, input q16_t hi,
                                     output logic hit);
    hit = 1'b0;
    if (lo == hi) return v;
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic drive_beat_t advance_loop(input q16_t sp, input q16_t ms);
    q16_t err, diff, d;
    logic acc_hit, drv_hit;
    drive_beat_t r;
    err = clip_q16(longint'(sp) - longint'(ms));
    integral = clip_q16(longint'(integral) + longint'(mul_q16(err, ki_dt)));
    integral = bound_q16(integral, acc_lo, acc_hi, acc_hit);
    diff = clip_q16(longint'(err) - longint'(prior_error));
    prior_error = err;
    d = clip_q16(longint'(mul_q16(kp, err)) + longint'(integral)
                 + longint'(mul_q16(kd_dt, diff)));
    if (speed_mode) d = clip_q16(longint'(d) + longint'(last_drive));
    d = bound_q16(d, drv_lo, drv_hi, drv_hit);
    if (speed_mode && d > -DEADBAND_Q && d < DEADBAND_Q) d = Q16_ZERO;
    last_drive = d;
    // The integral is cleared only after this beat's drive has used it.
    if (sp == Q16_ZERO) integral = Q16_ZERO;
    r.drive = d;
    r.clamped = drv_hit;
    return r;
  endfunction

  always @(posedge clk) begin
    drive_beat_t got, want;
    if (!rst_n) begin
      kp = '0; ki_dt = '0; kd_dt = '0; speed_mode = 1'b0;
      drv_lo = '0; drv_hi = '0; acc_lo = '0; acc_hi = '0;
      integral = '0; prior_error = '0; last_drive = '0;
      predicted_drives.delete();
      error_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_KP_GAIN:    kp = cfg_wdata;
          REG_KI_DT_GAIN: ki_dt = cfg_wdata;
          REG_KD_DT_GAIN: kd_dt = cfg_wdata;
          REG_INCR_MODE:  speed_mode = cfg_wdata[0];
          REG_DRIVE_LOW:  drv_lo = cfg_wdata;
          REG_DRIVE_HIGH: drv_hi = cfg_wdata;
          REG_ACCUM_LOW:  acc_lo = cfg_wdata;
          REG_ACCUM_HIGH: acc_hi = cfg_wdata;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        predicted_drives.push_back(advance_loop(in_mon.setpoint, in_mon.measurement));
      if (out_mon.valid && out_mon.ready) begin
        got.drive = out_mon.drive;
        got.clamped = out_mon.drive_clamped;
        if (predicted_drives.size() == 0) begin
          if (error_count < 10)
            $display("%0t: unexpected drive beat %0d clamped %b", $realtime,
                     got.drive, got.clamped);
          error_count <= error_count + 1;
        end else begin
          want = predicted_drives.pop_front();
          if (got.drive !== want.drive || got.clamped !== want.clamped) begin
            if (error_count < 10)
              $display("%0t: drive mismatch: expected %0d clamped %b, got %0d clamped %b",
                       $realtime, want.drive, want.clamped, got.drive, got.clamped);
            error_count <= error_count + 1;
          end
        end
      end
    end
    outstanding <= predicted_drives.size();
  end

endmodule

### tb/sv/tb_top.sv
// Top of the PID controller step unit testbench: clock, reset, register
// programming, setpoint/measurement stimulus and the verdict.
// Depends on pid_stp_pkg, pid_stp_if.sv, the RTL top and pid_step_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pid_stp_pkg::*;

  localparam q16_t ONE_Q       = 32'sd65536;
  localparam int   ITEM_TARGET = 1850;
  localparam int   CYCLE_LIMIT = 400000;

  typedef struct {
    q16_t kp, ki, kd;
    logic speed;
    q16_t drv_lo, drv_hi, acc_lo, acc_hi;
  } loop_settings_t;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     cfg_we;
  cfg_reg_t cfg_index;
  q16_t     cfg_wdata;
  int       mismatch_total;
  int       awaited_drives;
  int       cycle_count = 0;
  int       in_gap_pct = 0;
  int       out_stall_pct = 0;

  pid_stp_in_if  in_bus ();
  pid_stp_out_if out_bus ();

  pid_controller_step_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  pid_step_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_bus),
    .out_mon    (out_bus),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .error_count(mismatch_total),
    .outstanding(awaited_drives)
  );

  always #10ns clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Result-side back-pressure in bursts.
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_stall_pct != 0 && $urandom_range(1, 100) <= out_stall_pct) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
    end
  end

  task automatic set_reg(input cfg_reg_t idx, input q16_t val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic load_settings(input loop_settings_t s);
    q16_t mode_word;
    // Only bit 0 of the mode register matters; the rest is filled at random.
    mode_word = $urandom;
    mode_word[0] = s.speed;
    set_reg(REG_KP_GAIN, s.kp);
    set_reg(REG_KI_DT_GAIN, s.ki);
    set_reg(REG_KD_DT_GAIN, s.kd);
    set_reg(REG_INCR_MODE, mode_word);
    set_reg(REG_DRIVE_LOW, s.drv_lo);
    set_reg(REG_DRIVE_HIGH, s.drv_hi);
    set_reg(REG_ACCUM_LOW, s.acc_lo);
    set_reg(REG_ACCUM_HIGH, s.acc_hi);
    cfg_we <= 1'b0;
  endtask

  task automatic put_beat(input q16_t sp, input q16_t ms);
    if (in_gap_pct != 0 && $urandom_range(1, 100) <= in_gap_pct) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.setpoint <= sp;
    in_bus.measurement <= ms;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  // Drops the input valid and waits until every predicted drive has come back.
  task automatic drain;
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (awaited_drives != 0);
    repeat (8) @(posedge clk);
  endtask

  function automatic q16_t rand_signed(input int unsigned span);
    q16_t m;
    m = $urandom_range(0, span);
    return $urandom_range(0, 1) ? -m : m;
  endfunction

  function automatic q16_t pick_gain();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return rand_signed(4 * 65536);
      4, 5:       return $urandom_range(0, 65536);
      6:          return $urandom;
      7:          return Q16_MAX;
      8:          return Q16_MIN;
      default:    return Q16_ZERO;
    endcase
  endfunction

  function automatic void pick_limits(output q16_t lo, output q16_t hi);
    case ($urandom_range(0, 7))
      0: begin
        // equal limits switch the clamp off
        lo = rand_signed(200 * 65536);
        hi = lo;
      end
      1: begin
        lo = $urandom_range(0, 100 * 65536);
        hi = -q16_t'($urandom_range(0, 100 * 65536));
      end
      2: begin
        lo = Q16_MIN;
        hi = Q16_MAX;
      end
      3: begin
        lo = $urandom;
        hi = $urandom;
      end
      default: begin
        lo = -q16_t'($urandom_range(0, 200 * 65536));
        hi = $urandom_range(0, 200 * 65536);
      end
    endcase
  endfunction

  function automatic loop_settings_t pick_settings();
    loop_settings_t s;
    s.kp = pick_gain();
    s.ki = pick_gain();
    s.kd = pick_gain();
    s.speed = $urandom_range(0, 1);
    pick_limits(s.drv_lo, s.drv_hi);
    pick_limits(s.acc_lo, s.acc_hi);
    return s;
  endfunction

  task automatic put_random_beat;
    q16_t sp, ms;
    case ($urandom_range(0, 11))
      0: begin
        sp = Q16_ZERO;
        ms = rand_signed(100 * 65536);
      end
      1: begin
        sp = $urandom;
        ms = $urandom;
      end
      2: begin
        sp = $urandom_range(0, 1) ? Q16_MAX : Q16_MIN;
        ms = $urandom_range(0, 1) ? Q16_MAX : Q16_MIN;
      end
      3: begin
        sp = rand_signed(100 * 65536);
        ms = $urandom;
      end
      default: begin
        // measurement tracking the setpoint, as in a settling loop
        sp = rand_signed(100 * 65536);
        ms = sp + rand_signed(($urandom_range(0, 1) ? 2 : 30) * 65536);
      end
    endcase
    put_beat(sp, ms);
  endtask

  initial begin
    loop_settings_t s;
    int sent, n;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= REG_KP_GAIN;
    cfg_wdata <= '0;
    in_bus.valid <= 1'b0;
    in_bus.setpoint <= '0;
    in_bus.measurement <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    in_gap_pct = 30;
    out_stall_pct = 30;

    // Position mode, ordered limits: integral wind-up into its clamp, a zero
    // setpoint clearing it, and saturated errors hitting the drive clamp.
    s = '{kp: ONE_Q, ki: 8 * ONE_Q, kd: ONE_Q / 4, speed: 1'b0,
          drv_lo: -100 * ONE_Q, drv_hi: 100 * ONE_Q,
          acc_lo: -50 * ONE_Q, acc_hi: 50 * ONE_Q};
    load_settings(s);
    put_beat(Q16_ZERO, Q16_ZERO);
    put_beat(10 * ONE_Q, 4 * ONE_Q);
    put_beat(10 * ONE_Q, 4 * ONE_Q);
    put_beat(Q16_ZERO, 4 * ONE_Q);
    put_beat(Q16_MAX, Q16_MIN);
    put_beat(Q16_MIN, Q16_MAX);
    put_beat(5 * ONE_Q, 5 * ONE_Q);
    drain();

    // Speed mode with both clamps off: deadband and saturating accumulation.
    s = '{kp: ONE_Q, ki: ONE_Q / 2, kd: Q16_ZERO, speed: 1'b1,
          drv_lo: 5 * ONE_Q, drv_hi: 5 * ONE_Q,
          acc_lo: 7 * ONE_Q, acc_hi: 7 * ONE_Q};
    load_settings(s);
    put_beat(3 * ONE_Q, Q16_ZERO);
    put_beat(30 * ONE_Q, Q16_ZERO);
    put_beat(30 * ONE_Q, 25 * ONE_Q);
    put_beat(-40 * ONE_Q, Q16_ZERO);
    put_beat(Q16_MAX, Q16_MIN);
    put_beat(Q16_MAX, Q16_MIN);
    put_beat(Q16_ZERO, Q16_ZERO);
    drain();

    // Crossed limits on both clamps and extreme gains.
    s = '{kp: Q16_MAX, ki: Q16_MIN, kd: Q16_MIN, speed: 1'b0,
          drv_lo: 50 * ONE_Q, drv_hi: -50 * ONE_Q,
          acc_lo: 10 * ONE_Q, acc_hi: -10 * ONE_Q};
    load_settings(s);
    put_beat(ONE_Q, Q16_ZERO);
    put_beat(-ONE_Q, Q16_ZERO);
    put_beat(Q16_ZERO, Q16_ZERO);
    put_beat(Q16_MIN, Q16_ZERO);
    put_beat(100 * ONE_Q, -100 * ONE_Q);
    drain();

    // Speed mode with the clamps at the extremes of the range.
    s = '{kp: Q16_MIN, ki: ONE_Q, kd: Q16_MAX, speed: 1'b1,
          drv_lo: Q16_MIN, drv_hi: Q16_MAX, acc_lo: Q16_MIN, acc_hi: Q16_MAX};
    load_settings(s);
    put_beat(Q16_MAX, Q16_ZERO);
    put_beat(Q16_MIN, Q16_ZERO);
    put_beat(32'sd1, Q16_ZERO);
    drain();

    sent = 0;
    while (sent < ITEM_TARGET) begin
      n = $urandom_range(40, 160);
      if (n > ITEM_TARGET - sent) n = ITEM_TARGET - sent;
      load_settings(pick_settings());
      if (sent >= ITEM_TARGET - 300) begin
        in_gap_pct = 0;
        out_stall_pct = 0;
      end else begin
        in_gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
        out_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      end
      repeat (n) put_random_beat();
      drain();
      sent += n;
    end

    if (mismatch_total == 0 && awaited_drives == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule
